// ----- rtl/lbhw_pkg.sv -----
// lbhw_pkg: shared types, codes and constants of the lockout backoff and hour window block
// no dependencies; imported by lockout_backoff_and_hour_window

package lbhw_pkg;

	// field widths
	localparam int unsigned OP_W      = 3;
	localparam int unsigned ELAPSED_W = 16;
	localparam int unsigned HOUR_W    = 5;
	localparam int unsigned MINUTE_W  = 6;
	localparam int unsigned SECOND_W  = 6;
	localparam int unsigned VERDICT_W = 2;
	localparam int unsigned SECS_W    = 18;
	localparam int unsigned WAIT_W    = 20;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned STEP_W    = 16;
	localparam int unsigned PROD_W    = COUNT_W + STEP_W;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 20;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 48;

	// time constants
	localparam logic [HOUR_W-1:0]   HOURS_PER_DAY  = 5'd24;
	localparam logic [HOUR_W-1:0]   LAST_HOUR      = 5'd23;
	localparam logic [MINUTE_W-1:0] LAST_MINUTE    = 6'd59;
	localparam logic [SECOND_W-1:0] LAST_SECOND    = 6'd60;
	localparam logic [16:0]         SECS_PER_HOUR  = 17'd3600;
	localparam logic [11:0]         SECS_PER_MIN   = 12'd60;
	localparam logic [COUNT_W-1:0]  SAT_FAILURES   = 8'd255;
	localparam logic [SECS_W-1:0]   SECS_NONE      = '1;

	// register reset values
	localparam logic [HOUR_W-1:0] WIN_START_RST = 5'd8;
	localparam logic [HOUR_W-1:0] HOUR_TO_RST   = 5'd20;
	localparam logic [STEP_W-1:0] STEP_RST      = 16'd5000;
	localparam logic [WAIT_W-1:0] CAP_RST       = 20'd600000;

	typedef enum logic [OP_W-1:0] {
		OP_ARM     = 3'd0,
		OP_ATTEMPT = 3'd1,
		OP_SUCCESS = 3'd2,
		OP_TICK    = 3'd3,
		OP_CHECK   = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CODE_SET      = 3'd0,
		REG_HOURS_ENABLED = 3'd1,
		REG_WIN_START     = 3'd2,
		REG_HOUR_TO       = 3'd3,
		REG_STORED_FAIL   = 3'd4,
		REG_STEP          = 3'd5,
		REG_CAP           = 3'd6
	} reg_idx_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_ALLOW   = 2'd0,
		VERDICT_LOCKED  = 2'd1,
		VERDICT_OUTSIDE = 2'd2
	} verdict_t;

	// one result item
	typedef struct packed {
		logic [COUNT_W-1:0]   failure_count;
		logic [WAIT_W-1:0]    wait_ms;
		logic [SECS_W-1:0]    seconds_until_open;
		logic [VERDICT_W-1:0] verdict;
	} result_t;

	// hour h lies in the window [from, to), wrapping past midnight; equal ends mean no limit
	function automatic logic hour_ok(input logic [HOUR_W-1:0] h,
		input logic [HOUR_W-1:0] from, input logic [HOUR_W-1:0] to);
		logic ok;
		if (from == to) begin
			ok = 1'b1;
		end else if (from < to) begin
			ok = (h >= from) && (h < to);
		end else begin
			ok = (h >= from) || (h < to);
		end
		return ok;
	endfunction

endpackage

// ----- rtl/lockout_backoff_and_hour_window.sv -----
// lockout_backoff_and_hour_window: failure backoff timer with an allowed-hours check
// depends on lbhw_pkg
//
// Usage:
// - s_axis carries one operation per transaction: tuser holds the operation code
//   (arm, failed attempt, success, tick, check), tdata the time fields.
// - m_axis returns exactly one result per input transaction, in order: verdict,
//   seconds until the window opens (-1 if none), remaining wait and failure count.
// - cfg writes one register per transaction (cfg_index selects it); cfg_ready is
//   always high. Write only while no transaction is in flight.
// - m_axis_tvalid rises once an accepted item has passed the input register and then a
//   single pass of logic into the result register.
// - Throughput is one transaction per cycle while m_axis_tready is high; the failure
//   count and wait are updated as an item leaves the input register, so the next item
//   sees them. The longest path is the 8x16 penalty multiply followed by the cap compare.
// - When m_axis_tready is low the result register holds, the input register still
//   fills, and s_axis_tready drops only when both are occupied.
// - Reset clears both valid flags, the failure count and the wait, and loads the
//   register defaults (window 8 to 20, step 5000 ms, cap 600000 ms).

module lockout_backoff_and_hour_window
	import lbhw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata: elapsed_ms[15:0], locked[16], clock_valid[17], hour[22:18],
	//        minute[28:23], second[34:29], zero padding[39:35]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: operation[2:0]
	input  logic [OP_W-1:0]       s_axis_tuser,
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata: verdict[1:0], seconds_until_open[19:2], wait_ms[39:20],
	//        failure_count[47:40]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	// configuration registers
	logic                 code_set_q;
	logic                 hours_enabled_q;
	logic [HOUR_W-1:0]    win_start_q;
	logic [HOUR_W-1:0]    hour_to_q;
	logic [COUNT_W-1:0]   stored_failures_q;
	logic [STEP_W-1:0]    step_q;
	logic [WAIT_W-1:0]    cap_q;

	// lockout state
	logic [COUNT_W-1:0]   tally_q;
	logic [WAIT_W-1:0]    wait_q;

	// input register
	logic                 valid_s1;
	logic [OP_W-1:0]      op_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic                 locked_s1;
	logic                 clock_valid_s1;
	logic [HOUR_W-1:0]    hour_s1;
	logic [MINUTE_W-1:0]  minute_s1;
	logic [SECOND_W-1:0]  second_s1;

	// result register
	logic                 res_valid_q;
	result_t              res_q;

	// combinational
	logic                 advance;
	logic [COUNT_W-1:0]   tally_src;
	logic [PROD_W-1:0]    product;
	logic [WAIT_W-1:0]    penalty;
	logic [WAIT_W-1:0]    tick_wait;
	logic [COUNT_W-1:0]   tally_next;
	logic [WAIT_W-1:0]    wait_next;
	logic [HOUR_W-1:0]    hour_n;
	logic [MINUTE_W-1:0]  minute_c;
	logic [SECOND_W-1:0]  second_c;
	logic                 outside;
	logic [HOUR_W:0]      hours_ahead;
	logic [16:0]          ahead_secs;
	logic [11:0]          past_secs;
	logic [SECS_W-1:0]    open_secs;
	result_t              res_d;

	// handshakes
	assign advance       = valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_set_q        <= 1'b0;
			hours_enabled_q   <= 1'b0;
			win_start_q       <= WIN_START_RST;
			hour_to_q         <= HOUR_TO_RST;
			stored_failures_q <= '0;
			step_q            <= STEP_RST;
			cap_q             <= CAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CODE_SET:      code_set_q      <= cfg_data[0];
				REG_HOURS_ENABLED: hours_enabled_q <= cfg_data[0];
				REG_WIN_START: begin
					win_start_q <= (cfg_data[HOUR_W-1:0] > LAST_HOUR) ?
						WIN_START_RST : cfg_data[HOUR_W-1:0];
				end
				REG_HOUR_TO: begin
					hour_to_q <= (cfg_data[HOUR_W-1:0] > LAST_HOUR) ?
						HOUR_TO_RST : cfg_data[HOUR_W-1:0];
				end
				REG_STORED_FAIL:   stored_failures_q <= cfg_data[COUNT_W-1:0];
				REG_STEP:          step_q            <= cfg_data[STEP_W-1:0];
				REG_CAP:           cap_q             <= cfg_data[WAIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1          <= s_axis_tuser;
			elapsed_s1     <= s_axis_tdata[15:0];
			locked_s1      <= s_axis_tdata[16];
			clock_valid_s1 <= s_axis_tdata[17];
			hour_s1        <= s_axis_tdata[22:18];
			minute_s1      <= s_axis_tdata[28:23];
			second_s1      <= s_axis_tdata[34:29];
		end
	end

	// penalty = min(count * step, cap) from the count this item leaves behind
	always_comb begin
		if (op_s1 == OP_ARM) begin
			tally_src = stored_failures_q;
		end else if (tally_q != SAT_FAILURES) begin
			tally_src = tally_q + COUNT_W'(1);
		end else begin
			tally_src = tally_q;
		end
		product   = {{STEP_W{1'b0}}, tally_src} * {{COUNT_W{1'b0}}, step_q};
		penalty   = (product > {{(PROD_W-WAIT_W){1'b0}}, cap_q}) ?
			cap_q : product[WAIT_W-1:0];
		tick_wait = (wait_q > {{(WAIT_W-ELAPSED_W){1'b0}}, elapsed_s1}) ?
			(wait_q - {{(WAIT_W-ELAPSED_W){1'b0}}, elapsed_s1}) : '0;
	end

	// next lockout state
	always_comb begin
		tally_next = tally_q;
		wait_next  = wait_q;
		unique case (op_s1)
			OP_ARM, OP_ATTEMPT: begin
				tally_next = tally_src;
				wait_next  = penalty;
			end
			OP_SUCCESS: begin
				tally_next = '0;
				wait_next  = '0;
			end
			OP_TICK: wait_next = tick_wait;
			default: begin
			end
		endcase
	end

	// hour window check and seconds until the window opens
	always_comb begin
		hour_n   = (hour_s1 >= HOURS_PER_DAY) ? (hour_s1 - HOURS_PER_DAY) : hour_s1;
		minute_c = (minute_s1 > LAST_MINUTE) ? LAST_MINUTE : minute_s1;
		second_c = (second_s1 > LAST_SECOND) ? LAST_SECOND : second_s1;
		outside  = hours_enabled_q && clock_valid_s1 &&
			!hour_ok(hour_n, win_start_q, hour_to_q);
		// from an outside hour the window next opens at its start hour
		hours_ahead = {1'b0, win_start_q} - {1'b0, hour_n} +
			((win_start_q < hour_n) ? {1'b0, HOURS_PER_DAY} : '0);
		ahead_secs  = 17'(hours_ahead) * SECS_PER_HOUR;
		past_secs   = 12'(minute_c) * SECS_PER_MIN + 12'(second_c);
		open_secs   = {1'b0, ahead_secs} - {6'b0, past_secs};
	end

	// result item
	always_comb begin
		res_d.verdict            = VERDICT_ALLOW;
		res_d.seconds_until_open = SECS_NONE;
		res_d.wait_ms            = wait_next;
		res_d.failure_count      = tally_next;
		if ((op_s1 == OP_CHECK) && code_set_q) begin
			if (locked_s1) begin
				res_d.verdict = VERDICT_LOCKED;
			end else if (outside) begin
				res_d.verdict = VERDICT_OUTSIDE;
			end
			if (outside) begin
				res_d.seconds_until_open = open_secs;
			end
		end
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q     <= '0;
			wait_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				tally_q <= tally_next;
				wait_q  <= wait_next;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// arm and failed attempt never leave a wait above the cap
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (op_s1 == OP_ARM || op_s1 == OP_ATTEMPT) |=> wait_q <= cap_q)
		else $error("wait above cap after penalty load");

	// success clears count and wait
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (op_s1 == OP_SUCCESS) |=> (tally_q == '0) && (wait_q == '0))
		else $error("success did not clear lockout state");

	// tick never raises the wait
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (op_s1 == OP_TICK) |=> wait_q <= $past(wait_q))
		else $error("tick raised the wait");

	// an outside-hours verdict always carries a non-negative opening time
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.verdict == VERDICT_OUTSIDE) |-> !res_q.seconds_until_open[SECS_W-1])
		else $error("outside verdict without opening time");

	// an empty input register always takes a new item
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled while input register empty");

endmodule
